### hw/rtl/soc_pkg.sv
// Shared types, constants and the mux position table for the sensor offset block.
// No dependencies; used by the top level and the testbench.
package soc_pkg;

  localparam int MUX_CHANNELS = 16;
  localparam int LANES        = 9;
  localparam int SAMPLE_BITS  = 12;

  localparam int POS_W = 4;
  localparam int LANE_W = 4;
  localparam int RAW_W = 16;
  localparam int IDX_W = 8;
  localparam int MAG_W = 12;

  localparam int ORDER_LEN = 16;
  localparam logic [POS_W-1:0] MUX_ORDER [ORDER_LEN] = '{
    4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4,
    4'd0, 4'd1, 4'd2, 4'd3, 4'd12, 4'd13, 4'd14, 4'd15
  };

  localparam logic ACT_CALIBRATE = 1'b0;
  localparam logic ACT_MEASURE   = 1'b1;

  typedef struct packed {
    logic              action;
    logic [POS_W-1:0]  mux_position;
    logic [LANE_W-1:0] lane;
    logic [RAW_W-1:0]  raw_sample;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] sensor_index;
    logic [MAG_W-1:0] magnitude;
    logic             is_negative;
  } out_word_t;

endpackage

### hw/rtl/soc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module soc_ram #(
  parameter int Width = 12,
  parameter int Depth = 144
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### hw/rtl/sensor_offset_calibrate_correct_top.sv
// Top level: per-sensor offset store with running-mean calibration and correction.
// Depends on soc_pkg and soc_ram.
// Path: a measure word is registered in stage s1, then in the output register that drives out_valid_o.
// Throughput: one word per cycle; the offset RAM is read at accept and written back
// in the following cycle, with a forward path; a measure word held by out_stall_i stalls the input.
// Reset: all offsets read as mid-scale minus one at once through per-entry valid bits.
module sensor_offset_calibrate_correct_top #(
  parameter int MUX_CHANNELS = soc_pkg::MUX_CHANNELS,
  parameter int LANES        = soc_pkg::LANES,
  parameter int SAMPLE_BITS  = soc_pkg::SAMPLE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  soc_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output soc_pkg::out_word_t out_word_o
);

  localparam int Depth = MUX_CHANNELS * LANES;
  localparam int AW    = $clog2(Depth);
  localparam logic [SAMPLE_BITS-1:0] OffRst = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);

  logic                     accept;
  logic                     in_range;
  logic [AW-1:0]            slot;
  logic [soc_pkg::IDX_W-1:0] idx_d;

  logic                     s1_vld_q, s1_vld_d;
  logic                     s1_act_q;
  logic [AW-1:0]            s1_slot_q;
  logic [SAMPLE_BITS-1:0]   s1_smp_q;
  logic [soc_pkg::IDX_W-1:0] s1_idx_q;
  logic                     s1_fwd_q;
  logic [SAMPLE_BITS-1:0]   s1_fdat_q;
  logic                     s1_hit_q;

  logic [Depth-1:0]         vld_q;
  logic [SAMPLE_BITS-1:0]   rd_data;
  logic [SAMPLE_BITS-1:0]   off;
  logic [SAMPLE_BITS:0]     sum;
  logic [SAMPLE_BITS-1:0]   new_off;
  logic                     neg;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [soc_pkg::RAW_W-1:0] mag_ext;

  logic                     out_free;
  logic                     s1_go;
  logic                     s1_ready;
  logic                     wr_en;
  logic                     fwd_d;
  logic                     out_load;
  logic                     out_vld_q, out_vld_d;
  soc_pkg::out_word_t       out_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_range = (int'(in_word_i.mux_position) < MUX_CHANNELS) &&
                    (int'(in_word_i.lane) < LANES);
  assign slot     = AW'(int'(in_word_i.mux_position) * LANES + int'(in_word_i.lane));
  assign idx_d    = soc_pkg::IDX_W'(int'(soc_pkg::MUX_ORDER[in_word_i.mux_position]) +
                    (LANES - 1 - int'(in_word_i.lane)) * MUX_CHANNELS);

  assign off     = s1_fwd_q ? s1_fdat_q : (s1_hit_q ? rd_data : OffRst);
  assign sum     = {1'b0, off} + {1'b0, s1_smp_q};
  assign new_off = sum[SAMPLE_BITS:1];
  assign neg     = s1_smp_q < off;
  assign mag     = neg ? (off - s1_smp_q) : (s1_smp_q - off);
  assign mag_ext = soc_pkg::RAW_W'(mag);

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_go      = (s1_act_q == soc_pkg::ACT_CALIBRATE) || out_free;
  assign s1_ready   = !s1_vld_q || s1_go;
  assign in_stall_o = !s1_ready;
  assign wr_en      = s1_vld_q && (s1_act_q == soc_pkg::ACT_CALIBRATE);
  assign fwd_d      = wr_en && (s1_slot_q == slot);
  assign out_load   = s1_vld_q && (s1_act_q == soc_pkg::ACT_MEASURE) && out_free;

  assign s1_vld_d  = s1_ready ? (accept && in_range) : s1_vld_q;
  assign out_vld_d = out_load ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);

  soc_ram #(
    .Width (SAMPLE_BITS),
    .Depth (Depth)
  ) u_offset_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_slot_q),
    .wr_data_i (new_off),
    .rd_en_i   (accept),
    .rd_addr_i (slot),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (wr_en) begin
        vld_q[s1_slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_act_q  <= in_word_i.action;
      s1_slot_q <= slot;
      s1_smp_q  <= in_word_i.raw_sample[SAMPLE_BITS-1:0];
      s1_idx_q  <= idx_d;
      s1_fwd_q  <= fwd_d;
      s1_fdat_q <= new_off;
      s1_hit_q  <= vld_q[slot];
    end
    if (out_load) begin
      out_q.sensor_index <= s1_idx_q;
      out_q.magnitude    <= mag_ext[soc_pkg::MAG_W-1:0];
      out_q.is_negative  <= neg;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && (s1_act_q == soc_pkg::ACT_MEASURE) && out_vld_q && out_stall_i)
      |-> in_stall_o)
    else $error("input not stalled while measure word blocked");

  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(accept) && s1_fwd_q) |-> $past(wr_en && (s1_slot_q == slot)))
    else $error("forward flag without matching write");

  a_out_from_measure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_vld_q && (s1_act_q == soc_pkg::ACT_MEASURE)))
    else $error("output word without measure item");

  a_write_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> !(s1_vld_q && $stable(s1_slot_q) && !$past(accept)))
    else $error("calibrate word held in stage");

endmodule

### sim/tb_sensor_offset_calibrate_correct_top.sv
// Testbench for sensor_offset_calibrate_correct_top: offset calibration and correction per sensor.
// Mirrors the offset store in a class, predicts each correction and compares it with the output.
// Depends on soc_pkg and the RTL under hw/rtl.
module tb_sensor_offset_calibrate_correct_top;

  class offset_mirror;
    logic [soc_pkg::SAMPLE_BITS-1:0] offsets [soc_pkg::MUX_CHANNELS*soc_pkg::LANES];
    soc_pkg::out_word_t              pending_corrections [$];
    int                              errors;
    int                              n_calibrated;
    int                              n_measured;
    int                              n_ignored;
    int                              n_checked;

    function new();
      foreach (offsets[k]) begin
        offsets[k] = soc_pkg::SAMPLE_BITS'((1 << (soc_pkg::SAMPLE_BITS - 1)) - 1);
      end
      errors       = 0;
      n_calibrated = 0;
      n_measured   = 0;
      n_ignored    = 0;
      n_checked    = 0;
    endfunction

    function void note_word(soc_pkg::in_word_t w);
      logic [soc_pkg::SAMPLE_BITS-1:0] sample;
      logic [soc_pkg::SAMPLE_BITS-1:0] off;
      logic [soc_pkg::SAMPLE_BITS:0]   sum;
      soc_pkg::out_word_t              want;
      int                              slot;
      sample = w.raw_sample[soc_pkg::SAMPLE_BITS-1:0];
      if (int'(w.lane) >= soc_pkg::LANES || int'(w.mux_position) >= soc_pkg::MUX_CHANNELS) begin
        n_ignored++;
        return;
      end
      slot = int'(w.mux_position) * soc_pkg::LANES + int'(w.lane);
      off  = offsets[slot];
      if (w.action == soc_pkg::ACT_CALIBRATE) begin
        sum           = {1'b0, off} + {1'b0, sample};
        offsets[slot] = sum[soc_pkg::SAMPLE_BITS:1];
        n_calibrated++;
        return;
      end
      want.is_negative  = (sample < off);
      want.magnitude    = want.is_negative ? soc_pkg::MAG_W'(off - sample)
                                           : soc_pkg::MAG_W'(sample - off);
      want.sensor_index = soc_pkg::IDX_W'(int'(soc_pkg::MUX_ORDER[w.mux_position])
                          + (soc_pkg::LANES - 1 - int'(w.lane)) * soc_pkg::MUX_CHANNELS);
      pending_corrections.push_back(want);
      n_measured++;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_word(soc_pkg::out_word_t got);
      soc_pkg::out_word_t want;
      if (pending_corrections.size() == 0) begin
        report($sformatf("unexpected word, index %0d magnitude %0d", got.sensor_index,
                         got.magnitude));
        return;
      end
      want = pending_corrections.pop_front();
      n_checked++;
      if (got.sensor_index !== want.sensor_index)
        report($sformatf("word %0d sensor_index %0d, want %0d", n_checked, got.sensor_index,
                         want.sensor_index));
      if (got.magnitude !== want.magnitude)
        report($sformatf("word %0d magnitude %0d, want %0d", n_checked, got.magnitude,
                         want.magnitude));
      if (got.is_negative !== want.is_negative)
        report($sformatf("word %0d is_negative %0b, want %0b", n_checked, got.is_negative,
                         want.is_negative));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  soc_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  soc_pkg::out_word_t out_word_o;

  offset_mirror tracker;
  bit           in_quiet = 1'b1;
  bit           out_quiet = 1'b1;
  int           hot_pos [4];
  int           hot_lane [4];

  sensor_offset_calibrate_correct_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_word(in_word_i);
      if (out_valid_o && !out_stall_i) tracker.check_word(out_word_o);
    end
  end

  initial begin
    #5_000_000;
    $display("tb_sensor_offset_calibrate_correct_top: errors");
    $finish;
  end

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input soc_pkg::in_word_t w, input int gap);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic soc_pkg::in_word_t make_word(logic act, int pos, int lane, int raw);
    soc_pkg::in_word_t w;
    w.action       = act;
    w.mux_position = soc_pkg::POS_W'(pos);
    w.lane         = soc_pkg::LANE_W'(lane);
    w.raw_sample   = soc_pkg::RAW_W'(raw);
    return w;
  endfunction

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic soc_pkg::in_word_t random_word();
    soc_pkg::in_word_t                               w;
    logic [soc_pkg::RAW_W-soc_pkg::SAMPLE_BITS-1:0] upper;
    logic [soc_pkg::SAMPLE_BITS-1:0]                 s;
    int                                              k;
    int                                              pos;
    int                                              lane;
    upper = (soc_pkg::RAW_W - soc_pkg::SAMPLE_BITS)'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      pos  = $urandom_range(0, soc_pkg::MUX_CHANNELS - 1);
      lane = $urandom_range(soc_pkg::LANES, 15);
    end else if ($urandom_range(0, 1) == 0) begin
      k    = $urandom_range(0, 3);
      pos  = hot_pos[k];
      lane = hot_lane[k];
    end else begin
      pos  = $urandom_range(0, soc_pkg::MUX_CHANNELS - 1);
      lane = $urandom_range(0, soc_pkg::LANES - 1);
    end
    case ($urandom_range(0, 7))
      0: s = '0;
      1: s = '1;
      2: s = 12'h7ff;
      3: s = 12'h800;
      4: begin
        if (lane < soc_pkg::LANES) begin
          s = tracker.offsets[pos * soc_pkg::LANES + lane]
              + soc_pkg::SAMPLE_BITS'($urandom_range(0, 2)) - 1'b1;
        end else begin
          s = soc_pkg::SAMPLE_BITS'($urandom);
        end
      end
      default: s = soc_pkg::SAMPLE_BITS'($urandom);
    endcase
    w = make_word(($urandom_range(0, 4) < 2) ? soc_pkg::ACT_CALIBRATE : soc_pkg::ACT_MEASURE,
                  pos, lane, int'({upper, s}));
    return w;
  endfunction

  // receiver: stall a random number of cycles, then take one word
  initial begin
    int n;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      n = draw_gap(out_quiet);
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    soc_pkg::in_word_t directed [$];
    int                counted;
    int                k;
    int                waited;
    soc_pkg::in_word_t w;
    tracker = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   0,  0, 16'h0000));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,  15,  8, 16'hffff));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   8,  4, 16'hf7ff));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   7,  3, 16'h5800));
    directed.push_back(make_word(soc_pkg::ACT_CALIBRATE, 3,  2, 16'h0fff));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   3,  2, 16'h0000));
    directed.push_back(make_word(soc_pkg::ACT_CALIBRATE, 3,  2, 16'ha000));
    directed.push_back(make_word(soc_pkg::ACT_CALIBRATE, 3,  2, 16'h1000));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   3,  2, 16'h0fff));
    directed.push_back(make_word(soc_pkg::ACT_CALIBRATE, 12, 8, 16'hffff));
    directed.push_back(make_word(soc_pkg::ACT_CALIBRATE, 12, 8, 16'hffff));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   12, 8, 16'h0fff));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   5,  9, 16'h0123));
    directed.push_back(make_word(soc_pkg::ACT_CALIBRATE, 5,  9, 16'h0000));
    directed.push_back(make_word(soc_pkg::ACT_CALIBRATE, 5, 15, 16'hffff));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   5, 15, 16'hffff));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   5,  1, 16'h07ff));
    directed.push_back(make_word(soc_pkg::ACT_CALIBRATE, 11, 6, 16'h0000));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   10, 6, 16'h0000));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   11, 6, 16'h0400));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   11, 6, 16'h03ff));
    directed.push_back(make_word(soc_pkg::ACT_MEASURE,   0,  8, 16'h8001));
    foreach (directed[i]) send_word(directed[i], (i < 12) ? 0 : $urandom_range(0, 3));

    counted = directed.size();
    while (counted < 1750) begin
      if (counted % 200 == 0) begin
        in_quiet  = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
        for (k = 0; k < 4; k++) begin
          hot_pos[k]  = $urandom_range(0, soc_pkg::MUX_CHANNELS - 1);
          hot_lane[k] = $urandom_range(0, soc_pkg::LANES - 1);
        end
      end
      w = random_word();
      send_word(w, draw_gap(in_quiet));
      counted++;
    end
    in_valid_i = 1'b0;

    waited = 0;
    while (tracker.pending_corrections.size() != 0 && waited < 100_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (tracker.pending_corrections.size() != 0)
      tracker.report($sformatf("%0d corrections never arrived",
                               tracker.pending_corrections.size()));

    $display("run: %0d calibrations, %0d corrections checked, %0d out-of-range words dropped",
             tracker.n_calibrated, tracker.n_checked, tracker.n_ignored);
    $display("run: %0d mismatches", tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb_sensor_offset_calibrate_correct_top: clean");
    end else begin
      $display("tb_sensor_offset_calibrate_correct_top: errors");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/soc_pkg.sv
hw/rtl/soc_ram.sv
hw/rtl/sensor_offset_calibrate_correct_top.sv
sim/tb_sensor_offset_calibrate_correct_top.sv
